FILE: design/fld_pkg.sv
// Package for the per-flow flowlet detector: sizes, table entry and result types,
// the saturating count helper and the slot mapping. It depends on nothing else.
package fld_pkg;

  localparam int FLOW_SLOTS     = 1024;
  localparam int SLOT_BITS      = $clog2(FLOW_SLOTS);
  localparam int IN_SLOT_BITS   = 10;
  localparam int TS_BITS        = 64;
  localparam int COUNT_BITS     = 32;
  localparam int OUT_BITS       = 32;
  localparam logic [TS_BITS-1:0] GAP_LIMIT_RESET = TS_BITS'(1000000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE    = COUNT_BITS'(1);

  // One row of the flow table.
  typedef struct packed {
    logic                  valid;
    logic [TS_BITS-1:0]    last_ts;
    logic [COUNT_BITS-1:0] pkt_cnt;
    logic [COUNT_BITS-1:0] total;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Result of one request.
  typedef struct packed {
    logic [OUT_BITS-1:0] cur_pkts;
    logic [OUT_BITS-1:0] number;
    logic                new_flowlet;
    logic                first_packet;
    logic [OUT_BITS-1:0] closed_pkts;
  } result_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_ONE;
  endfunction

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [IN_SLOT_BITS-1:0] s);
    slot_of = SLOT_BITS'(s % FLOW_SLOTS);
  endfunction

endpackage

FILE: design/fld_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old word when read and write hit the same address. No dependencies.
module fld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/fld_update.sv
// Per-packet update of one flow table row: gap test, flowlet open/close, counts.
// Depends on fld_pkg.
module fld_update (
  input  fld_pkg::entry_t                  cur_entry,
  input  logic [fld_pkg::TS_BITS-1:0]      ts,
  input  logic [fld_pkg::TS_BITS-1:0]      gap_limit,
  output fld_pkg::entry_t                  next_entry,
  output fld_pkg::result_t                 res
);

  logic [fld_pkg::TS_BITS-1:0]    gap;
  logic                           long_gap;
  logic [fld_pkg::COUNT_BITS-1:0] closed;

  // wrapping gap, compared unsigned
  assign gap      = ts - cur_entry.last_ts;
  assign long_gap = gap > gap_limit;

  always_comb begin
    next_entry         = cur_entry;
    next_entry.valid   = 1'b1;
    next_entry.last_ts = ts;
    closed             = '0;
    res.new_flowlet    = 1'b0;
    res.first_packet   = 1'b0;
    if (!cur_entry.valid) begin
      next_entry.pkt_cnt = fld_pkg::COUNT_ONE;
      next_entry.total   = fld_pkg::COUNT_ONE;
      res.first_packet   = 1'b1;
    end else if (long_gap) begin
      closed             = cur_entry.pkt_cnt;
      next_entry.pkt_cnt = fld_pkg::COUNT_ONE;
      next_entry.total   = fld_pkg::sat_inc(cur_entry.total);
      res.new_flowlet    = 1'b1;
    end else begin
      next_entry.pkt_cnt = fld_pkg::sat_inc(cur_entry.pkt_cnt);
    end
    res.cur_pkts    = fld_pkg::OUT_BITS'(next_entry.pkt_cnt);
    res.number      = fld_pkg::OUT_BITS'(next_entry.total);
    res.closed_pkts = fld_pkg::OUT_BITS'(closed);
  end

endmodule

FILE: design/per_flow_flowlet_detector_top.sv
// Top level of the per-flow flowlet detector.
// Depends on fld_pkg, fld_ram and fld_update.
//
// Each request is one packet: a flow table slot and a microsecond timestamp. The
// block keeps one row per slot (valid mark, last timestamp, current flowlet packet
// count, flowlet total) in a single RAM and answers every request with one result:
// current flowlet size, flowlet number, new-flowlet and first-packet flags, and the
// size of the flowlet just closed. A packet whose wrapping 64-bit gap from the slot's
// last timestamp is strictly greater than gap_limit opens a new flowlet; counts
// saturate. Throughput is one request per cycle while out_stall is low, set by the
// single RAM read port and single write port; back-to-back packets of the same slot
// are served by forwarding the row just written. An accepted request is held in
// stage 1 while its row is read and updated, then loaded into the output register.
// After reset the block sweeps the table clear, one row per cycle, holding in_stall
// high meanwhile; configuration writes are taken during the sweep. Write gap_limit
// only while the block is idle.
module per_flow_flowlet_detector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fld_pkg::IN_SLOT_BITS-1:0] in_flow_slot,
  input  logic [fld_pkg::TS_BITS-1:0]      in_timestamp_us,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fld_pkg::OUT_BITS-1:0]     out_current_flowlet_packets,
  output logic [fld_pkg::OUT_BITS-1:0]     out_flowlet_number,
  output logic                             out_new_flowlet,
  output logic                             out_first_packet,
  output logic [fld_pkg::OUT_BITS-1:0]     out_closed_flowlet_packets,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fld_pkg::TS_BITS-1:0]      cfg_gap_limit
);

  // configuration register
  logic [fld_pkg::TS_BITS-1:0]   gap_limit_r;

  // clearing sweep
  logic                          clearing_r, clearing_nxt;
  logic [fld_pkg::SLOT_BITS-1:0] clr_addr_r, clr_addr_nxt;

  // stage 1: request held while its row is read
  logic                          s1_valid_r, s1_valid_nxt;
  logic [fld_pkg::SLOT_BITS-1:0] s1_slot_r;
  logic [fld_pkg::TS_BITS-1:0]   s1_ts_r;
  logic                          fwd_r;
  fld_pkg::entry_t               fwd_entry_r;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  fld_pkg::result_t              out_res_r;

  logic                          in_accept;
  logic                          s1_adv;
  logic [fld_pkg::SLOT_BITS-1:0] in_slot;
  logic [fld_pkg::ENTRY_BITS-1:0] rd_word;
  fld_pkg::entry_t               s1_entry;
  fld_pkg::entry_t               upd_entry;
  fld_pkg::result_t              upd_res;
  logic                          ram_we;
  logic [fld_pkg::SLOT_BITS-1:0] ram_waddr;
  fld_pkg::entry_t               ram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= fld_pkg::GAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gap_limit_r <= cfg_gap_limit;
    end
  end

  // Advance stage 1 when the output register is empty or being drained.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold requests during the sweep and while stage 1 cannot move on.
  assign in_stall  = clearing_r || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;
  assign in_slot   = fld_pkg::slot_of(in_flow_slot);

  // Sweep control: write zero rows until the last slot is done.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + fld_pkg::SLOT_BITS'(1);
      if (clr_addr_r == fld_pkg::SLOT_BITS'(fld_pkg::FLOW_SLOTS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Table write port: sweep first, otherwise the row updated by stage 1.
  assign ram_we    = clearing_r || s1_adv;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_slot_r;
  assign ram_wdata = clearing_r ? '0 : upd_entry;

  fld_ram #(
    .WIDTH (fld_pkg::ENTRY_BITS),
    .DEPTH (fld_pkg::FLOW_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_slot),
    .rdata (rd_word)
  );

  // The RAM returns the old row when the request ahead writes the same slot
  // in the same cycle; take the forwarded row instead.
  assign s1_entry = fwd_r ? fwd_entry_r : fld_pkg::entry_t'(rd_word);

  fld_update u_update (
    .cur_entry  (s1_entry),
    .ts         (s1_ts_r),
    .gap_limit  (gap_limit_r),
    .next_entry (upd_entry),
    .res        (upd_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_accept) begin
        fwd_r <= s1_adv && (s1_slot_r == in_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_slot_r   <= in_slot;
      s1_ts_r     <= in_timestamp_us;
      fwd_entry_r <= upd_entry;
    end
  end

  // Output register: load on advance, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_current_flowlet_packets = out_res_r.cur_pkts;
  assign out_flowlet_number          = out_res_r.number;
  assign out_new_flowlet             = out_res_r.new_flowlet;
  assign out_first_packet            = out_res_r.first_packet;
  assign out_closed_flowlet_packets  = out_res_r.closed_pkts;

endmodule

FILE: design/fld_checker.sv
// Port-level checks for the per-flow flowlet detector, bound to the top level.
// Depends on fld_pkg and per_flow_flowlet_detector_top.
module fld_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fld_pkg::OUT_BITS-1:0] out_current_flowlet_packets,
  input logic [fld_pkg::OUT_BITS-1:0] out_flowlet_number,
  input logic                         out_new_flowlet,
  input logic                         out_first_packet,
  input logic [fld_pkg::OUT_BITS-1:0] out_closed_flowlet_packets
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_flowlet_packets)
      && $stable(out_flowlet_number) && $stable(out_closed_flowlet_packets))
    else $error("stalled result changed");

  // First packet opens flowlet one with one packet and closes nothing.
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_packet |-> !out_new_flowlet
      && out_current_flowlet_packets == fld_pkg::OUT_BITS'(1)
      && out_flowlet_number == fld_pkg::OUT_BITS'(1)
      && out_closed_flowlet_packets == '0)
    else $error("bad first-packet result");

  // A new flowlet starts at one packet and closes a non-empty one.
  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_flowlet |-> out_current_flowlet_packets == fld_pkg::OUT_BITS'(1)
      && out_closed_flowlet_packets != '0 && out_flowlet_number != '0)
    else $error("bad new-flowlet result");

  // Without a new flowlet nothing is closed, and counts are never zero.
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_new_flowlet |-> out_closed_flowlet_packets == '0
      && out_current_flowlet_packets != '0 && out_flowlet_number != '0)
    else $error("bad continuing-flowlet result");

endmodule

bind per_flow_flowlet_detector_top fld_checker u_fld_checker (
  .clk                         (clk),
  .rst_n                       (rst_n),
  .out_valid                   (out_valid),
  .out_stall                   (out_stall),
  .out_current_flowlet_packets (out_current_flowlet_packets),
  .out_flowlet_number          (out_flowlet_number),
  .out_new_flowlet             (out_new_flowlet),
  .out_first_packet            (out_first_packet),
  .out_closed_flowlet_packets  (out_closed_flowlet_packets)
);
